[sv/hcb_pkg.sv]
// ----------------------------------------------------------------------------
// hcb_pkg
// Shared types and codes of the Huffman code builder.
// ----------------------------------------------------------------------------
package hcb_pkg;

   localparam logic [1:0] CMD_LOAD  = 2'd0;
   localparam logic [1:0] CMD_BUILD = 2'd1;
   localparam logic [1:0] CMD_FETCH = 2'd2;
   localparam logic [1:0] CMD_NOP   = 2'd3;

   localparam logic [1:0] STS_BUILT = 2'd0;
   localparam logic [1:0] STS_CODE  = 2'd1;
   localparam logic [1:0] STS_ERROR = 2'd2;

   localparam int WEIGHT_W = 32;
   localparam int PATH_W   = 64;
   localparam int CODE_W   = 63;
   localparam int LEN_W    = 6;

   typedef enum logic [1:0] {
      PH_LOADING,
      PH_WALKING,
      PH_DONE
   } phase_type;

   typedef enum logic [1:0] {
      RET_HEAP,
      RET_POP1,
      RET_POP2
   } sift_ret_type;

   typedef enum logic {
      DESC_BUILD,
      DESC_FETCH
   } desc_ret_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_FILL,
      S_H_START,
      S_H_X1,
      S_H_X2,
      S_SD_A,
      S_SD_B,
      S_SD_C,
      S_SD_D,
      S_M_START,
      S_P_A,
      S_P_B,
      S_P_C,
      S_P_D,
      S_N_WR,
      S_N_WR2,
      S_U_A,
      S_U_B,
      S_U_C,
      S_ROOT,
      S_ROOT2,
      S_DL_A,
      S_DL_B,
      S_F_SYM,
      S_F_REV,
      S_A_A,
      S_A_B,
      S_A_C
   } state_type;

endpackage

[sv/hcb_ram.sv]
// ----------------------------------------------------------------------------
// hcb_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module hcb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

[sv/huffman_code_builder.sv]
// ----------------------------------------------------------------------------
// huffman_code_builder
// Builds a Huffman tree from loaded (symbol, frequency) pairs in a binary
// min-heap and hands out one leaf code per fetch request.
// ----------------------------------------------------------------------------
// Usage:
//   Drive req_command/req_symbol/req_frequency and raise start; the request
//   is taken at a clock edge where start is high and busy is low.
//   Load (0) gives no response. Build (1) answers once,
//   with status built, or error when nothing is loaded. Fetch (2) answers
//   with one code per request, rsp_last_code marking the final leaf, or error
//   before a build or after the last code. Command 3 is dropped.
//   Each response sits on the rsp_ ports for one cycle with rsp_valid high;
//   the receiver cannot stall it.
// Sequencing:
//   Build sifts the heap one level at a time, paced by the single read
//   port of the heap and weight memories. Fetch reads the symbol, reverses
//   the path into the code bits serially, then climbs while the node is a
//   right child; when a next leaf exists, it steps to the right sibling and
//   descends left below it.
// Reset:
//   Synchronous, clears control state only; no memory is swept. The block is
//   idle and ready to load once reset drops.
// ----------------------------------------------------------------------------
module huffman_code_builder #(
   parameter int MAX_SYMBOLS   = 256,
   parameter int MAX_CODE_BITS = 63
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_command,
   input  logic [7:0]  req_symbol,
   input  logic [23:0] req_frequency,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_out_symbol,
   output logic [5:0]  rsp_code_length,
   output logic [62:0] rsp_code_bits,
   output logic        rsp_last_code
);

   import hcb_pkg::*;

   localparam int HW    = $clog2(MAX_SYMBOLS);
   localparam int NODES = 2 * MAX_SYMBOLS - 1;
   localparam int NW    = $clog2(NODES);
   localparam int LW    = $clog2(MAX_SYMBOLS + 1);
   localparam int EW    = LW + 1;

   // control
   state_type    state_ff, state_in;
   sift_ret_type sret_ff, sret_in;
   desc_ret_type dret_ff, dret_in;
   phase_type    phase_ff, phase_in;
   logic [LW-1:0] leaf_cnt_ff, leaf_cnt_in;
   logic [LW-1:0] size_ff, size_in;
   logic [NW-1:0] ncount_ff, ncount_in;

   // build datapath
   logic [HW-1:0] fill_ff, fill_in;
   logic [HW-1:0] outer_ff, outer_in;
   logic [HW-1:0] hole_ff, hole_in;
   logic [HW-1:0] pidx_ff, pidx_in;
   logic [NW-1:0] x_ff, x_in;
   logic [WEIGHT_W-1:0] wx_ff, wx_in;
   logic [NW-1:0] idl_ff, idl_in;
   logic [WEIGHT_W-1:0] wl_ff, wl_in;
   logic [NW-1:0] idr_ff, idr_in;
   logic [NW-1:0] top_ff, top_in;
   logic [WEIGHT_W-1:0] wtop_ff, wtop_in;
   logic [NW-1:0] a_ff, a_in;
   logic [WEIGHT_W-1:0] wa_ff, wa_in;
   logic [NW-1:0] nn_ff, nn_in;
   logic [WEIGHT_W-1:0] wn_ff, wn_in;

   // walk datapath
   logic [NW-1:0] cur_ff, cur_in;
   logic [NW-1:0] root_ff, root_in;
   logic [NW-1:0] par_ff, par_in;
   logic [LW-1:0] depth_ff, depth_in;
   logic [PATH_W-1:0] path_ff, path_in;
   logic [PATH_W-1:0] tmp_ff, tmp_in;
   logic [CODE_W-1:0] code_ff, code_in;
   logic [LEN_W-1:0] cnt_ff, cnt_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [7:0] sym_ff, sym_in;

   // response
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;
   logic [7:0]  rsp_sym_ff, rsp_sym_in;
   logic [5:0]  rsp_len_ff, rsp_len_in;
   logic [62:0] rsp_bits_ff, rsp_bits_in;
   logic        rsp_last_ff, rsp_last_in;

   // memory ports
   logic          heap_we;
   logic [HW-1:0] heap_wa, heap_ra;
   logic [NW-1:0] heap_wd, heap_rd;
   logic          wt_we;
   logic [NW-1:0] wt_wa, wt_ra;
   logic [WEIGHT_W-1:0] wt_wd, wt_rd;
   logic          sy_we;
   logic [HW-1:0] sy_wa, sy_ra;
   logic [7:0]    sy_wd, sy_rd;
   logic          lt_we, rt_we, pa_we;
   logic [NW-1:0] lt_wa, lt_wd, lt_ra, lt_rd;
   logic [NW-1:0] rt_wa, rt_wd, rt_ra, rt_rd;
   logic [NW-1:0] pa_wa, pa_wd, pa_ra, pa_rd;

   // helpers
   logic [EW-1:0] l_e, r_e, size_e;
   logic [15:0]   dep16, dep16m1;
   logic [LW-1:0] eff_cnt;
   logic          accept, sift_done, l_win;
   logic [WEIGHT_W-1:0] best_w;

   assign accept  = start && (state_ff == S_IDLE);
   assign l_e     = EW'({hole_ff, 1'b1});
   assign r_e     = l_e + EW'(1);
   assign size_e  = EW'(size_ff);
   assign dep16   = 16'(depth_ff);
   assign dep16m1 = dep16 - 16'd1;

   hcb_ram #(.WIDTH(NW), .DEPTH(MAX_SYMBOLS)) u_heap (
      .clock(clock), .wr_en(heap_we), .wr_addr(heap_wa), .wr_data(heap_wd),
      .rd_addr(heap_ra), .rd_data(heap_rd));
   hcb_ram #(.WIDTH(WEIGHT_W), .DEPTH(NODES)) u_weight (
      .clock(clock), .wr_en(wt_we), .wr_addr(wt_wa), .wr_data(wt_wd),
      .rd_addr(wt_ra), .rd_data(wt_rd));
   hcb_ram #(.WIDTH(8), .DEPTH(MAX_SYMBOLS)) u_symbol (
      .clock(clock), .wr_en(sy_we), .wr_addr(sy_wa), .wr_data(sy_wd),
      .rd_addr(sy_ra), .rd_data(sy_rd));
   hcb_ram #(.WIDTH(NW), .DEPTH(NODES)) u_left (
      .clock(clock), .wr_en(lt_we), .wr_addr(lt_wa), .wr_data(lt_wd),
      .rd_addr(lt_ra), .rd_data(lt_rd));
   hcb_ram #(.WIDTH(NW), .DEPTH(NODES)) u_right (
      .clock(clock), .wr_en(rt_we), .wr_addr(rt_wa), .wr_data(rt_wd),
      .rd_addr(rt_ra), .rd_data(rt_rd));
   hcb_ram #(.WIDTH(NW), .DEPTH(NODES)) u_parent (
      .clock(clock), .wr_en(pa_we), .wr_addr(pa_wa), .wr_data(pa_wd),
      .rd_addr(pa_ra), .rd_data(pa_rd));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_LOADING;
         leaf_cnt_ff  <= '0;
         size_ff      <= '0;
         ncount_ff    <= '0;
         path_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         leaf_cnt_ff  <= leaf_cnt_in;
         size_ff      <= size_in;
         ncount_ff    <= ncount_in;
         path_ff      <= path_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sret_ff       <= sret_in;
      dret_ff       <= dret_in;
      fill_ff       <= fill_in;
      outer_ff      <= outer_in;
      hole_ff       <= hole_in;
      pidx_ff       <= pidx_in;
      x_ff          <= x_in;
      wx_ff         <= wx_in;
      idl_ff        <= idl_in;
      wl_ff         <= wl_in;
      idr_ff        <= idr_in;
      top_ff        <= top_in;
      wtop_ff       <= wtop_in;
      a_ff          <= a_in;
      wa_ff         <= wa_in;
      nn_ff         <= nn_in;
      wn_ff         <= wn_in;
      cur_ff        <= cur_in;
      root_ff       <= root_in;
      par_ff        <= par_in;
      depth_ff      <= depth_in;
      tmp_ff        <= tmp_in;
      code_ff       <= code_in;
      cnt_ff        <= cnt_in;
      len_ff        <= len_in;
      sym_ff        <= sym_in;
      rsp_status_ff <= rsp_status_in;
      rsp_sym_ff    <= rsp_sym_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_bits_ff   <= rsp_bits_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_comb begin
      state_in    = state_ff;
      sret_in     = sret_ff;
      dret_in     = dret_ff;
      phase_in    = phase_ff;
      leaf_cnt_in = leaf_cnt_ff;
      size_in     = size_ff;
      ncount_in   = ncount_ff;
      fill_in     = fill_ff;
      outer_in    = outer_ff;
      hole_in     = hole_ff;
      pidx_in     = pidx_ff;
      x_in        = x_ff;
      wx_in       = wx_ff;
      idl_in      = idl_ff;
      wl_in       = wl_ff;
      idr_in      = idr_ff;
      top_in      = top_ff;
      wtop_in     = wtop_ff;
      a_in        = a_ff;
      wa_in       = wa_ff;
      nn_in       = nn_ff;
      wn_in       = wn_ff;
      cur_in      = cur_ff;
      root_in     = root_ff;
      par_in      = par_ff;
      depth_in    = depth_ff;
      path_in     = path_ff;
      tmp_in      = tmp_ff;
      code_in     = code_ff;
      cnt_in      = cnt_ff;
      len_in      = len_ff;
      sym_in      = sym_ff;

      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_sym_in    = rsp_sym_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_bits_in   = rsp_bits_ff;
      rsp_last_in   = rsp_last_ff;

      heap_we = 1'b0; heap_wa = '0; heap_wd = '0; heap_ra = '0;
      wt_we   = 1'b0; wt_wa   = '0; wt_wd   = '0; wt_ra   = '0;
      sy_we   = 1'b0; sy_wa   = '0; sy_wd   = '0; sy_ra   = '0;
      lt_we   = 1'b0; lt_wa   = '0; lt_wd   = '0; lt_ra   = '0;
      rt_we   = 1'b0; rt_wa   = '0; rt_wd   = '0; rt_ra   = '0;
      pa_we   = 1'b0; pa_wa   = '0; pa_wd   = '0; pa_ra   = '0;

      eff_cnt   = (phase_ff != PH_LOADING) ? '0 : leaf_cnt_ff;
      sift_done = 1'b0;
      l_win     = wl_ff < wx_ff;
      best_w    = l_win ? wl_ff : wx_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_command)
                  CMD_LOAD: begin
                     // a load after a build drops the old set
                     phase_in    = PH_LOADING;
                     leaf_cnt_in = eff_cnt;
                     if (EW'(eff_cnt) < EW'(MAX_SYMBOLS)) begin
                        wt_we       = 1'b1;
                        wt_wa       = NW'(eff_cnt);
                        wt_wd       = WEIGHT_W'(req_frequency);
                        sy_we       = 1'b1;
                        sy_wa       = HW'(eff_cnt);
                        sy_wd       = req_symbol;
                        leaf_cnt_in = eff_cnt + LW'(1);
                     end
                  end
                  CMD_BUILD: begin
                     if (leaf_cnt_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STS_ERROR;
                        rsp_sym_in    = '0;
                        rsp_len_in    = '0;
                        rsp_bits_in   = '0;
                        rsp_last_in   = 1'b0;
                     end else begin
                        fill_in   = '0;
                        size_in   = leaf_cnt_ff;
                        ncount_in = NW'(leaf_cnt_ff);
                        state_in  = S_FILL;
                     end
                  end
                  CMD_FETCH: begin
                     if (phase_ff != PH_WALKING) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STS_ERROR;
                        rsp_sym_in    = '0;
                        rsp_len_in    = '0;
                        rsp_bits_in   = '0;
                        rsp_last_in   = 1'b0;
                     end else begin
                        // cap deep codes, then reverse the path serially
                        len_in   = (dep16 < 16'(MAX_CODE_BITS)) ? LEN_W'(depth_ff)
                                                                 : LEN_W'(MAX_CODE_BITS);
                        cnt_in   = len_in;
                        tmp_in   = path_ff;
                        code_in  = '0;
                        sy_ra    = HW'(cur_ff);
                        state_in = S_F_SYM;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_FILL: begin
            heap_we = 1'b1;
            heap_wa = fill_ff;
            heap_wd = NW'(fill_ff);
            if (EW'(fill_ff) == EW'(leaf_cnt_ff) - EW'(1)) begin
               if (leaf_cnt_ff >= LW'(2)) begin
                  outer_in = HW'((leaf_cnt_ff >> 1) - LW'(1));
                  state_in = S_H_START;
               end else begin
                  state_in = S_ROOT;
               end
            end else begin
               fill_in = fill_ff + HW'(1);
            end
         end

         S_H_START: begin
            heap_ra  = outer_ff;
            hole_in  = outer_ff;
            state_in = S_H_X1;
         end
         S_H_X1: begin
            x_in     = heap_rd;
            wt_ra    = heap_rd;
            state_in = S_H_X2;
         end
         S_H_X2: begin
            wx_in    = wt_rd;
            sret_in  = RET_HEAP;
            state_in = S_SD_A;
         end

         // sift down with a hole: x moves down until no child is lighter
         S_SD_A: begin
            if (l_e >= size_e) begin
               heap_we   = 1'b1;
               heap_wa   = hole_ff;
               heap_wd   = x_ff;
               sift_done = 1'b1;
            end else begin
               heap_ra  = HW'(l_e);
               state_in = S_SD_B;
            end
         end
         S_SD_B: begin
            idl_in   = heap_rd;
            wt_ra    = heap_rd;
            heap_ra  = HW'(r_e);
            state_in = S_SD_C;
         end
         S_SD_C: begin
            wl_in    = wt_rd;
            idr_in   = heap_rd;
            wt_ra    = heap_rd;
            state_in = S_SD_D;
         end
         S_SD_D: begin
            heap_we = 1'b1;
            heap_wa = hole_ff;
            if ((r_e < size_e) && (wt_rd < best_w)) begin
               heap_wd  = idr_ff;
               hole_in  = HW'(r_e);
               state_in = S_SD_A;
            end else if (l_win) begin
               heap_wd  = idl_ff;
               hole_in  = HW'(l_e);
               state_in = S_SD_A;
            end else begin
               heap_wd   = x_ff;
               sift_done = 1'b1;
            end
         end

         S_M_START: begin
            if (size_ff == LW'(1)) begin
               state_in = S_ROOT;
            end else begin
               sret_in  = RET_POP1;
               state_in = S_P_A;
            end
         end

         // pop: take the top, move the last slot into the hole at the root
         S_P_A: begin
            heap_ra  = '0;
            state_in = S_P_B;
         end
         S_P_B: begin
            top_in   = heap_rd;
            wt_ra    = heap_rd;
            heap_ra  = HW'(size_ff - LW'(1));
            state_in = S_P_C;
         end
         S_P_C: begin
            wtop_in  = wt_rd;
            x_in     = heap_rd;
            wt_ra    = heap_rd;
            size_in  = size_ff - LW'(1);
            state_in = S_P_D;
         end
         S_P_D: begin
            wx_in    = wt_rd;
            hole_in  = '0;
            state_in = S_SD_A;
         end

         S_N_WR: begin
            nn_in    = ncount_ff;
            wn_in    = wa_ff + wtop_ff;
            wt_we    = 1'b1;
            wt_wa    = ncount_ff;
            wt_wd    = wa_ff + wtop_ff;
            lt_we    = 1'b1;
            lt_wa    = ncount_ff;
            lt_wd    = a_ff;
            rt_we    = 1'b1;
            rt_wa    = ncount_ff;
            rt_wd    = top_ff;
            pa_we    = 1'b1;
            pa_wa    = a_ff;
            pa_wd    = ncount_ff;
            state_in = S_N_WR2;
         end
         S_N_WR2: begin
            pa_we     = 1'b1;
            pa_wa     = top_ff;
            pa_wd     = nn_ff;
            ncount_in = ncount_ff + NW'(1);
            hole_in   = HW'(size_ff);
            size_in   = size_ff + LW'(1);
            state_in  = S_U_A;
         end

         // sift up the new node
         S_U_A: begin
            if (hole_ff == '0) begin
               heap_we  = 1'b1;
               heap_wa  = '0;
               heap_wd  = nn_ff;
               state_in = S_M_START;
            end else begin
               pidx_in  = (hole_ff - HW'(1)) >> 1;
               heap_ra  = (hole_ff - HW'(1)) >> 1;
               state_in = S_U_B;
            end
         end
         S_U_B: begin
            x_in     = heap_rd;
            wt_ra    = heap_rd;
            state_in = S_U_C;
         end
         S_U_C: begin
            heap_we = 1'b1;
            heap_wa = hole_ff;
            if (wn_ff < wt_rd) begin
               heap_wd  = x_ff;
               hole_in  = pidx_ff;
               state_in = S_U_A;
            end else begin
               heap_wd  = nn_ff;
               state_in = S_M_START;
            end
         end

         S_ROOT: begin
            heap_ra  = '0;
            state_in = S_ROOT2;
         end
         S_ROOT2: begin
            cur_in   = heap_rd;
            root_in  = heap_rd;
            depth_in = '0;
            path_in  = '0;
            size_in  = '0;
            dret_in  = DESC_BUILD;
            state_in = S_DL_A;
         end

         // descend left to the first leaf below cur
         S_DL_A: begin
            if (EW'(cur_ff) >= EW'(leaf_cnt_ff)) begin
               if (dep16 < 16'(PATH_W)) begin
                  path_in[dep16[5:0]] = 1'b0;
               end
               depth_in = depth_ff + LW'(1);
               lt_ra    = cur_ff;
               state_in = S_DL_B;
            end else begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               if (dret_ff == DESC_BUILD) begin
                  phase_in      = PH_WALKING;
                  rsp_status_in = STS_BUILT;
                  rsp_sym_in    = '0;
                  rsp_len_in    = '0;
                  rsp_bits_in   = '0;
                  rsp_last_in   = 1'b0;
               end else begin
                  rsp_status_in = STS_CODE;
                  rsp_sym_in    = sym_ff;
                  rsp_len_in    = len_ff;
                  rsp_bits_in   = code_ff;
                  rsp_last_in   = 1'b0;
               end
            end
         end
         S_DL_B: begin
            cur_in   = lt_rd;
            state_in = S_DL_A;
         end

         S_F_SYM: begin
            sym_in   = sy_rd;
            state_in = S_F_REV;
         end
         S_F_REV: begin
            if (cnt_ff == '0) begin
               state_in = S_A_A;
            end else begin
               code_in = {code_ff[CODE_W-2:0], tmp_ff[0]};
               tmp_in  = tmp_ff >> 1;
               cnt_in  = cnt_ff - LEN_W'(1);
            end
         end

         // climb while cur is a right child, then step to the right sibling
         S_A_A: begin
            if (cur_ff == root_ff) begin
               phase_in      = PH_DONE;
               rsp_valid_in  = 1'b1;
               rsp_status_in = STS_CODE;
               rsp_sym_in    = sym_ff;
               rsp_len_in    = len_ff;
               rsp_bits_in   = code_ff;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end else begin
               pa_ra    = cur_ff;
               state_in = S_A_B;
            end
         end
         S_A_B: begin
            par_in   = pa_rd;
            rt_ra    = pa_rd;
            state_in = S_A_C;
         end
         S_A_C: begin
            if (rt_rd == cur_ff) begin
               cur_in   = par_ff;
               depth_in = depth_ff - LW'(1);
               state_in = S_A_A;
            end else begin
               cur_in = rt_rd;
               if (dep16m1 < 16'(PATH_W)) begin
                  path_in[dep16m1[5:0]] = 1'b1;
               end
               dret_in  = DESC_FETCH;
               state_in = S_DL_A;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (sift_done) begin
         case (sret_ff)
            RET_HEAP: begin
               if (outer_ff == '0) begin
                  state_in = S_M_START;
               end else begin
                  outer_in = outer_ff - HW'(1);
                  state_in = S_H_START;
               end
            end
            RET_POP1: begin
               a_in     = top_ff;
               wa_in    = wtop_ff;
               sret_in  = RET_POP2;
               state_in = S_P_A;
            end
            default: begin
               state_in = S_N_WR;
            end
         endcase
      end
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_out_symbol  = rsp_sym_ff;
   assign rsp_code_length = rsp_len_ff;
   assign rsp_code_bits   = rsp_bits_ff;
   assign rsp_last_code   = rsp_last_ff;

endmodule
